### design/bbl_pkg.sv
// Shared types, constants and the horizon table of the beacon blob locator.
// No dependencies; every other design file refers to it by scoped names.
package bbl_pkg;

	localparam int IMAGE_ROWS = 64;
	localparam int IMAGE_COLS = 128;

	localparam int GRAY_W  = 8;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 7;
	localparam int ANGLE_W = 12;
	localparam int HOR_W   = 7;
	localparam int COORD_W = 9;
	localparam int COUNT_W = 8;

	localparam logic [GRAY_W-1:0]  THRESHOLD_RESET = 8'd100;
	localparam logic [COORD_W-1:0] NOT_FOUND_CODE  = 9'd404;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

	// Classified-item queue and result queue depths
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam int HORIZON_STEPS = 9;

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [HOR_W-1:0]   horizon_t;

	localparam angle_t ANGLE_BOUND [HORIZON_STEPS] = '{
		12'd1420, 12'd1580, 12'd1760, 12'd1890, 12'd2050,
		12'd2310, 12'd2450, 12'd2620, 12'd2920
	};
	localparam horizon_t HORIZON_FOR_STEP [HORIZON_STEPS] = '{
		7'd64, 7'd47, 7'd42, 7'd40, 7'd36, 7'd30, 7'd27, 7'd24, 7'd18
	};

	typedef struct packed {
		logic [GRAY_W-1:0]  gray_pixel;
		logic [ROW_W-1:0]   row_index;
		logic [COL_W-1:0]   column_index;
		logic               frame_start;
		logic               frame_end;
		logic [ANGLE_W-1:0] tilt_angle;
	} pixel_t;

	typedef struct packed {
		logic               beacon_found;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COUNT_W-1:0] lit_area;
	} result_t;

	// Pixel after classification by the front part
	typedef struct packed {
		logic             lit;
		logic             in_image;
		logic             row_last;
		logic             frame_start;
		logic             frame_end;
		horizon_t         horizon;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] column_index;
	} class_t;

	// Handshake status of the back part
	typedef struct packed {
		logic cmd_pop;
		logic res_push;
		logic res_full;
	} back_status_t;

	// First table step whose bound lies above the angle; zero past the last bound
	function automatic horizon_t pick_horizon(input angle_t angle);
		horizon_t h;
		h = '0;
		for (int k = HORIZON_STEPS - 1; k >= 0; k--) begin
			if (angle < ANGLE_BOUND[k]) begin
				h = HORIZON_FOR_STEP[k];
			end
		end
		return h;
	endfunction

endpackage

### design/bbl_front.sv
// Front part: threshold register, pixel binarization and horizon lookup.
// Depends on bbl_pkg.
module bbl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbl_pkg::GRAY_W-1:0]    cfg_data,
	input  bbl_pkg::pixel_t               pixel,
	input  logic                          push,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output bbl_pkg::class_t               cmd_item
);

	logic [bbl_pkg::GRAY_W-1:0] threshold_q;

	// Take a threshold write on every transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bbl_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	// Forward a pixel into the queue when there is room
	assign cmd_push = push && !cmd_full;

	// Classify the pixel
	always_comb begin
		cmd_item.lit          = (pixel.gray_pixel >= threshold_q);
		cmd_item.in_image     = (int'(pixel.row_index) < bbl_pkg::IMAGE_ROWS) &&
		                        (int'(pixel.column_index) < bbl_pkg::IMAGE_COLS);
		cmd_item.row_last     = (int'(pixel.column_index) == bbl_pkg::IMAGE_COLS - 1);
		cmd_item.frame_start  = pixel.frame_start;
		cmd_item.frame_end    = pixel.frame_end;
		cmd_item.horizon      = bbl_pkg::pick_horizon(pixel.tilt_angle);
		cmd_item.row_index    = pixel.row_index;
		cmd_item.column_index = pixel.column_index;
	end

endmodule

### design/bbl_cmd_queue.sv
// Short queue of classified pixels between the front and back parts.
// Depends on bbl_pkg.
module bbl_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  bbl_pkg::class_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output bbl_pkg::class_t rd_item,
	output logic            empty
);

	bbl_pkg::class_t                 entry_q [bbl_pkg::CMD_DEPTH];
	logic [bbl_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [bbl_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [bbl_pkg::CMD_CNT_W-1:0]   count_q;

	assign full    = (count_q == bbl_pkg::CMD_CNT_W'(bbl_pkg::CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = entry_q[rd_ptr_q];

	// Store an incoming item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/bbl_back.sv
// Back part: blob tracking state, row-end scan stop and the result queue.
// Depends on bbl_pkg.
module bbl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bbl_pkg::class_t       cmd_item,
	input  logic                  cmd_empty,
	output bbl_pkg::back_status_t status,
	output bbl_pkg::result_t      result,
	output logic                  empty,
	input  logic                  pop
);

	bbl_pkg::horizon_t             horizon_q;
	logic                          seen_q;
	logic                          stopped_q;
	logic [bbl_pkg::COL_W-1:0]     first_col_q;
	logic [bbl_pkg::ROW_W-1:0]     first_row_q;
	logic [bbl_pkg::COL_W-1:0]     last_col_q;
	logic [bbl_pkg::ROW_W-1:0]     last_row_q;
	logic [bbl_pkg::COUNT_W-1:0]   area_q;
	logic [bbl_pkg::COUNT_W-1:0]   row_cnt_q;
	logic [bbl_pkg::COUNT_W-1:0]   prev_cnt_q;

	bbl_pkg::horizon_t             horizon_d;
	logic                          seen_d;
	logic                          stopped_d;
	logic [bbl_pkg::COL_W-1:0]     first_col_d;
	logic [bbl_pkg::ROW_W-1:0]     first_row_d;
	logic [bbl_pkg::COL_W-1:0]     last_col_d;
	logic [bbl_pkg::ROW_W-1:0]     last_row_d;
	logic [bbl_pkg::COUNT_W-1:0]   area_d;
	logic [bbl_pkg::COUNT_W-1:0]   row_cnt_d;
	logic [bbl_pkg::COUNT_W-1:0]   prev_cnt_d;
	logic                          active;
	bbl_pkg::result_t              res_d;

	bbl_pkg::result_t              res_q [bbl_pkg::RES_DEPTH];
	logic [bbl_pkg::RES_PTR_W-1:0] res_wr_q;
	logic [bbl_pkg::RES_PTR_W-1:0] res_rd_q;
	logic [bbl_pkg::RES_CNT_W-1:0] res_cnt_q;
	logic                          res_full;
	logic                          res_pop;
	logic                          cmd_pop;
	logic                          res_push;

	// Hold a frame-end item while the result queue has no room
	assign res_full = (res_cnt_q == bbl_pkg::RES_CNT_W'(bbl_pkg::RES_DEPTH));
	assign cmd_pop  = !cmd_empty && (!cmd_item.frame_end || !res_full);
	assign res_push = cmd_pop && cmd_item.frame_end;
	assign empty    = (res_cnt_q == '0);
	assign res_pop  = pop && !empty;
	assign result   = res_q[res_rd_q];

	assign status.cmd_pop  = cmd_pop;
	assign status.res_push = res_push;
	assign status.res_full = res_full;

	// Next tracking state for the item at the head of the queue
	always_comb begin
		if (cmd_item.frame_start) begin
			horizon_d   = cmd_item.horizon;
			seen_d      = 1'b0;
			stopped_d   = 1'b0;
			first_col_d = '0;
			first_row_d = '0;
			last_col_d  = '0;
			last_row_d  = '0;
			area_d      = '0;
			row_cnt_d   = '0;
			prev_cnt_d  = '0;
		end else begin
			horizon_d   = horizon_q;
			seen_d      = seen_q;
			stopped_d   = stopped_q;
			first_col_d = first_col_q;
			first_row_d = first_row_q;
			last_col_d  = last_col_q;
			last_row_d  = last_row_q;
			area_d      = area_q;
			row_cnt_d   = row_cnt_q;
			prev_cnt_d  = prev_cnt_q;
		end

		active = !stopped_d && cmd_item.in_image &&
		         ({1'b0, cmd_item.row_index} >= horizon_d);

		// Record a lit pixel
		if (active && cmd_item.lit) begin
			if (!seen_d) begin
				first_col_d = cmd_item.column_index;
				first_row_d = cmd_item.row_index;
			end
			seen_d     = 1'b1;
			last_col_d = cmd_item.column_index;
			last_row_d = cmd_item.row_index;
			if (area_d != bbl_pkg::COUNT_MAX) begin
				area_d = area_d + 1'b1;
			end
			if (row_cnt_d != bbl_pkg::COUNT_MAX) begin
				row_cnt_d = row_cnt_d + 1'b1;
			end
		end

		// Close the row; stop at the first empty row after a non-empty one
		if (active && cmd_item.row_last) begin
			if (prev_cnt_d != '0 && row_cnt_d == '0) begin
				stopped_d = 1'b1;
			end else begin
				prev_cnt_d = row_cnt_d;
			end
			row_cnt_d = '0;
		end

		// Build the frame result
		if (area_d != '0) begin
			res_d.beacon_found = 1'b1;
			res_d.center_x     = bbl_pkg::COORD_W'(
			                     ({1'b0, first_col_d} + {1'b0, last_col_d}) >> 1);
			res_d.center_y     = bbl_pkg::COORD_W'(
			                     ({1'b0, first_row_d} + {1'b0, last_row_d}) >> 1);
			res_d.lit_area     = area_d;
		end else begin
			res_d.beacon_found = 1'b0;
			res_d.center_x     = bbl_pkg::NOT_FOUND_CODE;
			res_d.center_y     = bbl_pkg::NOT_FOUND_CODE;
			res_d.lit_area     = '0;
		end
	end

	// Update tracking state on each item taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q   <= '0;
			seen_q      <= 1'b0;
			stopped_q   <= 1'b0;
			first_col_q <= '0;
			first_row_q <= '0;
			last_col_q  <= '0;
			last_row_q  <= '0;
			area_q      <= '0;
			row_cnt_q   <= '0;
			prev_cnt_q  <= '0;
		end else if (cmd_pop) begin
			horizon_q   <= horizon_d;
			seen_q      <= seen_d;
			stopped_q   <= stopped_d;
			first_col_q <= first_col_d;
			first_row_q <= first_row_d;
			last_col_q  <= last_col_d;
			last_row_q  <= last_row_d;
			area_q      <= area_d;
			row_cnt_q   <= row_cnt_d;
			prev_cnt_q  <= prev_cnt_d;
		end
	end

	// Store a finished frame result
	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_d;
		end
	end

	// Advance result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/beacon_blob_locator.sv
// Top level of the beacon blob locator: front, item queue and back part.
// Depends on bbl_pkg, bbl_front, bbl_cmd_queue and bbl_back.
//
// Usage:
//   Pixels enter as a pixel_t on "pixel" with push/full: a transfer happens
//   on a rising edge with push high and full low. Pixels come bottom row
//   first, columns left to right; frame_start on the first pixel latches the
//   horizon from tilt_angle, frame_end on the last pixel produces one result.
//   Results leave as a result_t on "result" with empty/pop: the oldest
//   result is shown while empty is low and is taken on an edge with pop high.
//   The threshold is written through cfg_valid/cfg_ready/cfg_data while the
//   block is idle; cfg_ready is always high.
//   Throughput is one pixel per cycle while full is low. A frame's last
//   pixel is written into the item queue when it transfers; the tracking
//   logic passes its result into the result queue once that item is taken.
//   Reset clears the queues and tracking state and loads threshold 100.
//   When the receiver stalls, up to two results wait in the result queue;
//   a further frame end then holds in the four-entry item queue, and full
//   rises once that queue fills.
module beacon_blob_locator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bbl_pkg::pixel_t            pixel,
	input  logic                       push,
	output logic                       full,
	output bbl_pkg::result_t           result,
	output logic                       empty,
	input  logic                       pop,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bbl_pkg::GRAY_W-1:0] cfg_data
);

	logic                  cmd_push;
	bbl_pkg::class_t       cmd_in;
	bbl_pkg::class_t       cmd_out;
	logic                  cmd_full;
	logic                  cmd_empty;
	bbl_pkg::back_status_t back_status;

	assign full = cmd_full;

	// Classify incoming pixels
	bbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.push      (push),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd_item  (cmd_in)
	);

	// Decouple front and back
	bbl_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_item (cmd_in),
		.full    (cmd_full),
		.rd_en   (back_status.cmd_pop),
		.rd_item (cmd_out),
		.empty   (cmd_empty)
	);

	// Track the blob and queue results
	bbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_item  (cmd_out),
		.cmd_empty (cmd_empty),
		.status    (back_status),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

`ifndef SYNTHESIS
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.cmd_pop |-> !cmd_empty)
		else $error("back part took an item from an empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("transferred pixel missing from item queue");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.res_push |-> !back_status.res_full)
		else $error("result written into a full result queue");

	a_not_found_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.beacon_found) |-> (result.center_x == bbl_pkg::NOT_FOUND_CODE &&
		result.center_y == bbl_pkg::NOT_FOUND_CODE && result.lit_area == '0))
		else $error("empty frame result lacks not-found code");

	a_found_area: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.beacon_found) |-> (result.lit_area != '0))
		else $error("found result with zero area");
`endif

endmodule

### sim/beacon_blob_locator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the beacon blob locator: directed and random pixel streams,
// a pixel-by-pixel tracking predictor and an in-order queue of expected frame results.
// Depends on bbl_pkg and the beacon_blob_locator design files.
module beacon_blob_locator_test;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	bbl_pkg::pixel_t            pix_in    = '0;
	logic                       push      = 1'b0;
	logic                       full;
	bbl_pkg::result_t           frame_result;
	logic                       empty;
	logic                       pop       = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [bbl_pkg::GRAY_W-1:0] cfg_data  = '0;

	beacon_blob_locator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_in),
		.push      (push),
		.full      (full),
		.result    (frame_result),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus backlog, expected frame results and run statistics
	bbl_pkg::pixel_t  pixel_backlog[$];
	bbl_pkg::result_t frames_due[$];
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	int      pixels_queued  = 0;
	int      pixels_sent    = 0;
	int      frames_checked = 0;
	int      mismatches     = 0;

	// Tracking state of the predictor
	logic [bbl_pkg::GRAY_W-1:0]  trk_threshold = bbl_pkg::THRESHOLD_RESET;
	bbl_pkg::horizon_t           trk_horizon   = '0;
	logic                        trk_seen      = 1'b0;
	logic                        trk_stopped   = 1'b0;
	logic [bbl_pkg::COL_W-1:0]   trk_first_col = '0;
	logic [bbl_pkg::ROW_W-1:0]   trk_first_row = '0;
	logic [bbl_pkg::COL_W-1:0]   trk_last_col  = '0;
	logic [bbl_pkg::ROW_W-1:0]   trk_last_row  = '0;
	logic [bbl_pkg::COUNT_W-1:0] trk_area      = '0;
	logic [bbl_pkg::COUNT_W-1:0] trk_row_lit   = '0;
	logic [bbl_pkg::COUNT_W-1:0] trk_prev_lit  = '0;

	// Map the tilt reading to the lowest row number that is scanned
	function automatic bbl_pkg::horizon_t horizon_from_angle(input bbl_pkg::angle_t angle);
		if (angle < 12'd1420) return 7'd64;
		else if (angle < 12'd1580) return 7'd47;
		else if (angle < 12'd1760) return 7'd42;
		else if (angle < 12'd1890) return 7'd40;
		else if (angle < 12'd2050) return 7'd36;
		else if (angle < 12'd2310) return 7'd30;
		else if (angle < 12'd2450) return 7'd27;
		else if (angle < 12'd2620) return 7'd24;
		else if (angle < 12'd2920) return 7'd18;
		return 7'd0;
	endfunction

	task automatic clear_tracking();
		trk_horizon   = '0;
		trk_seen      = 1'b0;
		trk_stopped   = 1'b0;
		trk_first_col = '0;
		trk_first_row = '0;
		trk_last_col  = '0;
		trk_last_row  = '0;
		trk_area      = '0;
		trk_row_lit   = '0;
		trk_prev_lit  = '0;
	endtask

	// Advance the tracking state by one pixel; queue the frame result on frame end
	task automatic track_pixel(input bbl_pkg::pixel_t p);
		bbl_pkg::result_t            r;
		logic [bbl_pkg::COORD_W-1:0] sum;
		if (p.frame_start) begin
			clear_tracking();
			trk_horizon = horizon_from_angle(p.tilt_angle);
		end
		if (!trk_stopped && p.row_index < bbl_pkg::IMAGE_ROWS &&
		    p.column_index < bbl_pkg::IMAGE_COLS &&
		    {1'b0, p.row_index} >= trk_horizon) begin
			if (p.gray_pixel >= trk_threshold) begin
				if (!trk_seen) begin
					trk_seen      = 1'b1;
					trk_first_col = p.column_index;
					trk_first_row = p.row_index;
				end
				trk_last_col = p.column_index;
				trk_last_row = p.row_index;
				if (trk_area != bbl_pkg::COUNT_MAX) trk_area = trk_area + 1'b1;
				if (trk_row_lit != bbl_pkg::COUNT_MAX) trk_row_lit = trk_row_lit + 1'b1;
			end
			// Row end: stop on the first empty row after a lit one
			if (p.column_index == bbl_pkg::IMAGE_COLS - 1) begin
				if (trk_prev_lit != 0 && trk_row_lit == 0) trk_stopped = 1'b1;
				else trk_prev_lit = trk_row_lit;
				trk_row_lit = '0;
			end
		end
		if (p.frame_end) begin
			if (trk_area != 0) begin
				r.beacon_found = 1'b1;
				sum = {2'b00, trk_first_col} + {2'b00, trk_last_col};
				r.center_x = sum >> 1;
				sum = {3'b000, trk_first_row} + {3'b000, trk_last_row};
				r.center_y = sum >> 1;
				r.lit_area = trk_area;
			end else begin
				r.beacon_found = 1'b0;
				r.center_x     = bbl_pkg::NOT_FOUND_CODE;
				r.center_y     = bbl_pkg::NOT_FOUND_CODE;
				r.lit_area     = '0;
			end
			frames_due.push_back(r);
		end
	endtask

	task automatic report_field(input string field, input int want_v, input int got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
	endtask

	// Compare one transferred result with the oldest expectation
	task automatic check_frame(input bbl_pkg::result_t got);
		bbl_pkg::result_t want;
		if (frames_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with none expected, area %0d", $time, got.lit_area);
		end else begin
			want = frames_due.pop_front();
			frames_checked++;
			if (got.beacon_found !== want.beacon_found)
				report_field("beacon_found", want.beacon_found, got.beacon_found);
			if (got.center_x !== want.center_x)
				report_field("center_x", want.center_x, got.center_x);
			if (got.center_y !== want.center_y)
				report_field("center_y", want.center_y, got.center_y);
			if (got.lit_area !== want.lit_area)
				report_field("lit_area", want.lit_area, got.lit_area);
		end
	endtask

	// Driver: predict on each transfer, then hold, load the next pixel or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				track_pixel(pix_in);
				pixels_sent++;
			end
			if (!push || !full) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pix_in <= pixel_backlog.pop_front();
					push   <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) check_frame(frame_result);
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_pixel(input int gray, input int row, input int col,
	                         input bit fs, input bit fe, input int angle);
		bbl_pkg::pixel_t p;
		p.gray_pixel   = bbl_pkg::GRAY_W'(gray);
		p.row_index    = bbl_pkg::ROW_W'(row);
		p.column_index = bbl_pkg::COL_W'(col);
		p.frame_start  = fs;
		p.frame_end    = fe;
		p.tilt_angle   = bbl_pkg::ANGLE_W'(angle);
		pixel_backlog.push_back(p);
		pixels_queued++;
	endtask

	// Gray level on the requested side of the current threshold
	function automatic int gray_for(input bit lit);
		if (lit || trk_threshold == 0) return $urandom_range(255, trk_threshold);
		return $urandom_range(trk_threshold - 1);
	endfunction

	task automatic add_directed();
		// Single-pixel frames: lit, dark, and lit above a full horizon
		add_pixel(255, 63, bbl_pkg::IMAGE_COLS - 1, 1, 1, 4095);
		add_pixel(0, 0, 0, 1, 1, 4095);
		add_pixel(255, 63, 0, 1, 1, 0);
		// Horizon table edges
		add_pixel(255, 47, 9, 1, 1, 1420);
		add_pixel(255, 63, 9, 1, 1, 1419);
		add_pixel(255, 17, 9, 1, 1, 2919);
		add_pixel(255, 0, 9, 1, 1, 2920);
		// Gray exactly at the threshold and one below
		add_pixel(trk_threshold, 20, 5, 1, 0, 4095);
		add_pixel(trk_threshold - 1, 20, 6, 0, 1, 4095);
		// Empty row after a lit row stops the scan
		add_pixel(200, 10, 3, 1, 0, 4095);
		add_pixel(0, 10, bbl_pkg::IMAGE_COLS - 1, 0, 0, 4095);
		add_pixel(0, 9, bbl_pkg::IMAGE_COLS - 1, 0, 0, 4095);
		add_pixel(200, 8, 50, 0, 1, 4095);
		// Corner coordinates
		add_pixel(255, 63, 0, 1, 0, 4095);
		add_pixel(255, 0, bbl_pkg::IMAGE_COLS - 1, 0, 1, 4095);
		// Pixel with no frame start carries on the previous frame
		add_pixel(255, 5, 7, 0, 1, 0);
	endtask

	// One frame long enough to saturate both lit counters
	task automatic add_long_frame();
		add_pixel(gray_for(1), 40, 0, 1, 0, 4095);
		repeat (299) add_pixel(gray_for(1), 40, $urandom_range(bbl_pkg::IMAGE_COLS - 2), 0, 0,
		                       $urandom_range(4095));
		add_pixel(gray_for(0), 40, bbl_pkg::IMAGE_COLS - 1, 0, 0, $urandom_range(4095));
		add_pixel(gray_for(0), 39, bbl_pkg::IMAGE_COLS - 1, 0, 1, $urandom_range(4095));
	endtask

	// Well-formed frame of a few sparse rows; now and then the frame end is missing
	task automatic add_frame();
		int rows, pix, row, col, angle, k, j;
		bit empty_row, lit, fs, fe, broken_end;
		angle = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(4095, 2920);
		rows = $urandom_range(6, 1);
		row = $urandom_range(63, 4);
		broken_end = ($urandom_range(19) == 0);
		fs = 1'b1;
		for (k = 0; k < rows; k++) begin
			empty_row = ($urandom_range(3) == 0);
			pix = $urandom_range(4, 1);
			for (j = 0; j < pix; j++) begin
				if (j == pix - 1 && $urandom_range(9) != 0) col = bbl_pkg::IMAGE_COLS - 1;
				else col = $urandom_range(bbl_pkg::IMAGE_COLS - 2);
				lit = !empty_row && $urandom_range(1);
				fe = (k == rows - 1) && (j == pix - 1) && !broken_end;
				add_pixel(gray_for(lit), row, col, fs, fe, fs ? angle : $urandom_range(4095));
				fs = 1'b0;
			end
			// Mostly descend one row; sometimes jump anywhere
			if ($urandom_range(9) == 0) row = $urandom_range(63);
			else if (row > 0) row--;
		end
	endtask

	task automatic add_noise();
		repeat ($urandom_range(3, 1))
			add_pixel($urandom_range(255), $urandom_range(63),
			          $urandom_range(bbl_pkg::IMAGE_COLS - 1),
			          $urandom_range(7) == 0, $urandom_range(7) == 0, $urandom_range(4095));
	endtask

	task automatic add_random(input int budget, input bit with_long);
		int target;
		target = pixels_queued + budget;
		if (with_long) add_long_frame();
		while (pixels_queued < target) begin
			if ($urandom_range(9) == 0) add_noise();
			else add_frame();
		end
	endtask

	// Hold until every pixel is in and every result is out, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || push || frames_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [bbl_pkg::GRAY_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		trk_threshold = value;
		@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset threshold, no idling
		add_directed();
		add_random(400, 1);
		wait_idle();

		// All pixels lit, sender idling
		write_threshold(8'd0);
		send_idle_pct = 57;
		recv_stall_pct = 0;
		add_random(200, 0);
		wait_idle();

		// Only full white lit, receiver stalling
		write_threshold(8'd255);
		send_idle_pct = 0;
		recv_stall_pct = 57;
		add_random(400, 1);
		wait_idle();

		// Random threshold, both sides idling, with a full drain midway
		write_threshold(bbl_pkg::GRAY_W'($urandom_range(254, 1)));
		send_idle_pct = 33;
		recv_stall_pct = 33;
		add_directed();
		add_random(100, 0);
		wait_idle();
		add_random(100, 0);
		wait_idle();

		$display("Sent %0d pixels and checked %0d frame results", pixels_sent, frames_checked);
		$display("over thresholds 100, 0, 255 and one random, with %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

### beacon_blob_locator.f
design/bbl_pkg.sv
design/bbl_front.sv
design/bbl_cmd_queue.sv
design/bbl_back.sv
design/beacon_blob_locator.sv
sim/beacon_blob_locator_test.sv
